[hdl/frc_pkg.sv]
// Shared types, constants and helper functions of the frame receiver.
`default_nettype none
package frc_pkg;

    localparam int MAX_FRAME = 44;
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int CNT_W     = ($clog2(MAX_FRAME + 1) > 6) ? $clog2(MAX_FRAME + 1) : 6;

    localparam logic [7:0]  SYNC_A    = 8'hA5;
    localparam logic [7:0]  SYNC_B    = 8'h5A;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [19:0] TICK_MAX  = 20'hFFFFF;
    localparam logic [19:0] TIMEOUT_DEFAULT = 20'd50000;
    localparam logic [5:0]  LEN_PARAMETER = 6'd12;
    localparam logic [5:0]  LEN_ACTUATOR  = 6'd20;
    localparam logic [5:0]  LEN_MOTOR     = 6'd28;

    // Request kinds.
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_OVF  = 2'd2;

    // Status codes of result items.
    localparam logic [2:0] ST_PAYLOAD = 3'd0;
    localparam logic [2:0] ST_BAD_HDR = 3'd1;
    localparam logic [2:0] ST_BAD_LEN = 3'd2;
    localparam logic [2:0] ST_BAD_CRC = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;
    localparam logic [2:0] ST_OVF     = 3'd5;

    // Register indexes.
    localparam logic [2:0] REG_VERSION  = 3'd0;
    localparam logic [2:0] REG_TYPE_PAR = 3'd1;
    localparam logic [2:0] REG_TYPE_ACT = 3'd2;
    localparam logic [2:0] REG_TYPE_MOT = 3'd3;
    localparam logic [2:0] REG_TIMEOUT  = 3'd4;

    typedef struct packed {
        logic [7:0]  version;
        logic [7:0]  type_par;
        logic [7:0]  type_act;
        logic [7:0]  type_mot;
        logic [19:0] timeout;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic       hit;
        logic [1:0] cls;
        logic [5:0] want;
    } t_type_res;

    // First matching type code wins.
    function automatic t_type_res type_lookup(input t_cfg cfg, input logic [7:0] t);
        t_type_res r;
        r = '0;
        if (t == cfg.type_par) begin
            r.hit = 1'b1; r.cls = 2'd0; r.want = LEN_PARAMETER;
        end else if (t == cfg.type_act) begin
            r.hit = 1'b1; r.cls = 2'd1; r.want = LEN_ACTUATOR;
        end else if (t == cfg.type_mot) begin
            r.hit = 1'b1; r.cls = 2'd2; r.want = LEN_MOTOR;
        end
        return r;
    endfunction

    // One byte of CRC-16, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int n = 0; n < 8; n++) begin
            x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
        end
        return x;
    endfunction

endpackage
`default_nettype wire

[hdl/frc_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module frc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 44
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[hdl/frc_seq.sv]
// Sequencer: parses requests, checks header and CRC, resyncs and emits results.
`default_nettype none
module frc_seq (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire frc_pkg::t_cfg           i_cfg,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [1:0]              i_kind,
    input  wire logic [7:0]              i_rx_byte,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [2:0]                   o_status,
    output logic [1:0]                   o_frame_class,
    output logic [7:0]                   o_payload_byte,
    output logic [4:0]                   o_byte_index,
    output logic                         o_last,
    output frc_pkg::t_ram_req            o_ram,
    input  wire logic [7:0]              i_ram_rdata
);
    import frc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_HDR     = 10'b0000000010,
        S_SCAN    = 10'b0000000100,
        S_MOVE    = 10'b0000001000,
        S_TAIL    = 10'b0000010000,
        S_CRC     = 10'b0000100000,
        S_CHK     = 10'b0001000000,
        S_EMIT_RD = 10'b0010000000,
        S_EMIT_WR = 10'b0100000000,
        S_STAT    = 10'b1000000000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_fill, n_fill, r_target, n_target, r_k, n_k, r_i, n_i;
    logic [19:0]       r_idle, n_idle;
    logic              r_scan, n_scan, r_vok, n_vok, r_tok, n_tok, r_a, n_a;
    logic [5:0]        r_want, n_want;
    logic [1:0]        r_cls, n_cls;
    logic [7:0]        r_lo, n_lo;
    logic [15:0]       r_crc, n_crc;
    logic [2:0]        r_stat, n_stat;

    logic              r_ov, n_ov, r_olast, n_olast;
    logic [2:0]        r_ost, n_ost;
    logic [1:0]        r_ocls, n_ocls;
    logic [7:0]        r_obyte, n_obyte;
    logic [4:0]        r_oidx, n_oidx;

    logic              slot_free;
    logic [CNT_W-1:0]  rem, crc_n, pay_len;
    t_type_res         tl;
    logic              len_ok;

    assign slot_free  = !r_ov || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign rem        = r_fill - r_i;
    assign crc_n      = r_target - CNT_W'(4);
    assign pay_len    = r_target - CNT_W'(16);
    assign tl         = type_lookup(i_cfg, i_ram_rdata);
    assign len_ok     = ({i_ram_rdata, r_lo} == {10'd0, r_want});

    assign o_out_valid    = r_ov;
    assign o_status       = r_ost;
    assign o_frame_class  = r_ocls;
    assign o_payload_byte = r_obyte;
    assign o_byte_index   = r_oidx;
    assign o_last         = r_olast;

    always_comb begin
        logic [CNT_W-1:0] nf;
        logic [19:0]      inc;
        nf       = r_fill + CNT_W'(1);
        inc      = (r_idle != TICK_MAX) ? (r_idle + 20'd1) : r_idle;
        n_state  = r_state;
        n_fill   = r_fill;
        n_target = r_target;
        n_k      = r_k;
        n_i      = r_i;
        n_idle   = r_idle;
        n_scan   = r_scan;
        n_vok    = r_vok;
        n_tok    = r_tok;
        n_a      = r_a;
        n_want   = r_want;
        n_cls    = r_cls;
        n_lo     = r_lo;
        n_crc    = r_crc;
        n_stat   = r_stat;
        n_ov     = r_ov && i_out_stall;
        n_ost    = r_ost;
        n_ocls   = r_ocls;
        n_obyte  = r_obyte;
        n_oidx   = r_oidx;
        n_olast  = r_olast;
        o_ram    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_kind)
                        KIND_BYTE: begin
                            n_idle = '0;
                            if (r_fill == '0) begin
                                if (i_rx_byte == SYNC_A) begin
                                    o_ram.we = 1'b1; o_ram.waddr = '0; o_ram.wdata = i_rx_byte;
                                    n_fill = CNT_W'(1);
                                end
                            end else if (r_fill == CNT_W'(1)) begin
                                n_target = '0;
                                if (i_rx_byte == SYNC_B) begin
                                    o_ram.we = 1'b1; o_ram.waddr = ADDR_W'(1);
                                    o_ram.wdata = i_rx_byte;
                                    n_fill = CNT_W'(2);
                                end else if (i_rx_byte == SYNC_A) begin
                                    o_ram.we = 1'b1; o_ram.waddr = '0; o_ram.wdata = i_rx_byte;
                                    n_fill = CNT_W'(1);
                                end else begin
                                    n_fill = '0;
                                end
                            end else if (r_fill >= CNT_W'(MAX_FRAME)) begin
                                n_fill   = '0;
                                n_target = '0;
                            end else begin
                                o_ram.we    = 1'b1;
                                o_ram.waddr = r_fill[ADDR_W-1:0];
                                o_ram.wdata = i_rx_byte;
                                n_fill      = nf;
                                if (nf == CNT_W'(6)) begin
                                    n_i = '0; n_k = '0; n_scan = 1'b0;
                                    n_state = S_HDR;
                                end else if (r_target != '0 && nf == r_target) begin
                                    n_k = '0; n_crc = CRC_INIT;
                                    n_state = S_CRC;
                                end
                            end
                        end
                        KIND_TICK: begin
                            if (r_fill == '0) begin
                                n_idle = '0;
                            end else if (inc >= i_cfg.timeout) begin
                                n_fill = '0; n_target = '0; n_idle = '0;
                                n_stat = ST_TIMEOUT;
                                n_state = S_STAT;
                            end else begin
                                n_idle = inc;
                            end
                        end
                        KIND_OVF: begin
                            n_fill = '0; n_target = '0; n_idle = '0;
                            n_stat = ST_OVF;
                            n_state = S_STAT;
                        end
                        default: ;
                    endcase
                end
            end
            S_HDR: begin
                // Reads version, type, length low and high of the header at r_i.
                if (r_k < CNT_W'(4)) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = ADDR_W'(r_i + CNT_W'(2) + r_k);
                    n_k         = r_k + CNT_W'(1);
                end
                if (r_k == CNT_W'(1)) n_vok = (i_ram_rdata == i_cfg.version);
                if (r_k == CNT_W'(2)) begin
                    n_tok = tl.hit; n_want = tl.want; n_cls = tl.cls;
                end
                if (r_k == CNT_W'(3)) n_lo = i_ram_rdata;
                if (r_k == CNT_W'(4)) begin
                    n_k = '0;
                    if (!r_scan) begin
                        if (!(r_vok && r_tok)) begin
                            n_stat = ST_BAD_HDR; n_i = CNT_W'(1); n_state = S_SCAN;
                        end else if (!len_ok) begin
                            n_stat = ST_BAD_LEN; n_i = CNT_W'(1); n_state = S_SCAN;
                        end else begin
                            n_target = CNT_W'(16) + CNT_W'(r_want);
                            n_state  = S_IDLE;
                        end
                    end else if (r_vok && r_tok && len_ok) begin
                        n_state = S_MOVE;
                    end else begin
                        n_i = r_i + CNT_W'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_k == '0) begin
                    if (r_i + CNT_W'(1) >= r_fill) begin
                        n_state = S_TAIL;
                    end else begin
                        o_ram.re = 1'b1; o_ram.raddr = r_i[ADDR_W-1:0];
                        n_k = CNT_W'(1);
                    end
                end else if (r_k == CNT_W'(1)) begin
                    n_a = (i_ram_rdata == SYNC_A);
                    o_ram.re = 1'b1; o_ram.raddr = ADDR_W'(r_i + CNT_W'(1));
                    n_k = CNT_W'(2);
                end else begin
                    n_k = '0;
                    if (r_a && i_ram_rdata == SYNC_B) begin
                        if (rem >= CNT_W'(6)) begin
                            n_scan = 1'b1; n_state = S_HDR;
                        end else begin
                            n_state = S_MOVE;
                        end
                    end else begin
                        n_i = r_i + CNT_W'(1);
                    end
                end
            end
            S_MOVE: begin
                // Copies the pair found at r_i and everything after it to the front.
                if (r_k != '0) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = ADDR_W'(r_k - CNT_W'(1));
                    o_ram.wdata = i_ram_rdata;
                end
                if (r_k < rem) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = ADDR_W'(r_i + r_k);
                    n_k         = r_k + CNT_W'(1);
                end else begin
                    n_fill   = rem;
                    n_target = (rem >= CNT_W'(6)) ? (CNT_W'(16) + CNT_W'(r_want)) : '0;
                    n_k      = '0;
                    n_state  = S_STAT;
                end
            end
            S_TAIL: begin
                if (r_k == '0) begin
                    if (r_fill == '0) begin
                        n_target = '0; n_state = S_STAT;
                    end else begin
                        o_ram.re = 1'b1; o_ram.raddr = ADDR_W'(r_fill - CNT_W'(1));
                        n_k = CNT_W'(1);
                    end
                end else begin
                    n_k = '0;
                    n_target = '0;
                    if (i_ram_rdata == SYNC_A) begin
                        o_ram.we = 1'b1; o_ram.waddr = '0; o_ram.wdata = SYNC_A;
                        n_fill = CNT_W'(1);
                    end else begin
                        n_fill = '0;
                    end
                    n_state = S_STAT;
                end
            end
            S_CRC: begin
                // Streams bytes 2 .. target-3; the type byte is re-decoded on the way.
                if (r_k < crc_n) begin
                    o_ram.re = 1'b1; o_ram.raddr = ADDR_W'(r_k + CNT_W'(2));
                end
                if (r_k != '0) n_crc = crc_byte(r_crc, i_ram_rdata);
                if (r_k == CNT_W'(2)) n_cls = tl.cls;
                if (r_k == crc_n) begin
                    n_k = '0; n_state = S_CHK;
                end else begin
                    n_k = r_k + CNT_W'(1);
                end
            end
            S_CHK: begin
                if (r_k == '0) begin
                    o_ram.re = 1'b1; o_ram.raddr = ADDR_W'(r_target - CNT_W'(2));
                    n_k = CNT_W'(1);
                end else if (r_k == CNT_W'(1)) begin
                    n_lo = i_ram_rdata;
                    o_ram.re = 1'b1; o_ram.raddr = ADDR_W'(r_target - CNT_W'(1));
                    n_k = CNT_W'(2);
                end else begin
                    n_k = '0;
                    if ({i_ram_rdata, r_lo} == r_crc) begin
                        n_state = S_EMIT_RD;
                    end else begin
                        n_stat = ST_BAD_CRC; n_i = CNT_W'(1); n_state = S_SCAN;
                    end
                end
            end
            S_EMIT_RD: begin
                o_ram.re = 1'b1; o_ram.raddr = ADDR_W'(r_k + CNT_W'(14));
                n_state = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (slot_free) begin
                    n_ov = 1'b1; n_ost = ST_PAYLOAD; n_ocls = r_cls;
                    n_obyte = i_ram_rdata; n_oidx = r_k[4:0];
                    n_olast = (r_k + CNT_W'(1) == pay_len);
                    if (r_k + CNT_W'(1) == pay_len) begin
                        n_fill = '0; n_target = '0; n_k = '0; n_state = S_IDLE;
                    end else begin
                        n_k = r_k + CNT_W'(1); n_state = S_EMIT_RD;
                    end
                end
            end
            S_STAT: begin
                if (slot_free) begin
                    n_ov = 1'b1; n_ost = r_stat; n_ocls = '0; n_obyte = '0;
                    n_oidx = '0; n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_target <= '0;
            r_k      <= '0;
            r_idle   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_target <= n_target;
            r_k      <= n_k;
            r_idle   <= n_idle;
            r_ov     <= n_ov;
        end
        r_i     <= n_i;
        r_scan  <= n_scan;
        r_vok   <= n_vok;
        r_tok   <= n_tok;
        r_a     <= n_a;
        r_want  <= n_want;
        r_cls   <= n_cls;
        r_lo    <= n_lo;
        r_crc   <= n_crc;
        r_stat  <= n_stat;
        r_ost   <= n_ost;
        r_ocls  <= n_ocls;
        r_obyte <= n_obyte;
        r_oidx  <= n_oidx;
        r_olast <= n_olast;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAX_FRAME))
        else $error("fill count beyond buffer size");

    a_target_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_target == '0 || r_target == CNT_W'(28) || r_target == CNT_W'(36)
        || r_target == CNT_W'(44))
        else $error("illegal target count");

    a_stat_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STAT && slot_free) |=> (r_ov && r_olast && r_state == S_IDLE))
        else $error("status item not loaded");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_WR && slot_free && r_k + CNT_W'(1) == pay_len)
        |=> (r_fill == '0 && r_olast))
        else $error("payload run end did not empty the buffer");

endmodule
`default_nettype wire

[hdl/sync_length_crc_frame_receiver_top.sv]
// Top level of the frame receiver: register port, frame buffer and sequencer.
//
// Requests are bytes, microsecond ticks and overflow notices. A byte that completes
// neither a header nor a frame, or a tick that does not time out, is taken without
// leaving the idle state. An overflow or a timeout loads a status item, after any
// wait for the output register. The sixth byte of a frame starts a header check.
// The last byte of a frame starts a CRC walk over the stored frame, one byte per
// cycle, then the CRC compare, then each payload byte is read and emitted, again
// with any wait for the output register. After an error the buffer is searched
// position by position and candidate headers are checked again, then the tail is
// moved down at one byte per cycle. All of this is bound by the single read port
// of the 44-byte frame buffer. Status and payload items wait in an output register.
`default_nettype none
module sync_length_crc_frame_receiver_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [1:0]       o_frame_class,
    output logic [7:0]       o_payload_byte,
    output logic [4:0]       o_byte_index,
    output logic             o_last
);
    import frc_pkg::*;

    t_cfg       r_cfg;
    t_ram_req   ram_req;
    logic [7:0] ram_rdata;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.version  <= 8'd1;
            r_cfg.type_par <= 8'd0;
            r_cfg.type_act <= 8'd1;
            r_cfg.type_mot <= 8'd2;
            r_cfg.timeout  <= TIMEOUT_DEFAULT;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_VERSION:  r_cfg.version  <= pwdata[7:0];
                REG_TYPE_PAR: r_cfg.type_par <= pwdata[7:0];
                REG_TYPE_ACT: r_cfg.type_act <= pwdata[7:0];
                REG_TYPE_MOT: r_cfg.type_mot <= pwdata[7:0];
                REG_TIMEOUT:  r_cfg.timeout  <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_VERSION:  prdata = {24'd0, r_cfg.version};
            REG_TYPE_PAR: prdata = {24'd0, r_cfg.type_par};
            REG_TYPE_ACT: prdata = {24'd0, r_cfg.type_act};
            REG_TYPE_MOT: prdata = {24'd0, r_cfg.type_mot};
            REG_TIMEOUT:  prdata = {12'd0, r_cfg.timeout};
            default:      prdata = '0;
        endcase
    end

    frc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    frc_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_frame_class  (o_frame_class),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last         (o_last),
        .o_ram          (ram_req),
        .i_ram_rdata    (ram_rdata)
    );
endmodule
`default_nettype wire

[dv/sync_length_crc_frame_receiver_top_tb.sv]
// Self-checking testbench of the frame receiver: random-gap driver, stalling monitor, predictor.
`default_nettype none
module sync_length_crc_frame_receiver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import frc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] frame_class;
        logic [7:0] payload_byte;
        logic [4:0] byte_index;
        logic       last;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [1:0] i_kind = '0;
    logic [7:0] i_rx_byte = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [2:0] o_status;
    logic [1:0] o_frame_class;
    logic [7:0] o_payload_byte;
    logic [4:0] o_byte_index;
    logic o_last;

    sync_length_crc_frame_receiver_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_kind(i_kind), .i_rx_byte(i_rx_byte),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_frame_class(o_frame_class),
        .o_payload_byte(o_payload_byte), .o_byte_index(o_byte_index), .o_last(o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver model state.
    logic [7:0]  rx_buf [MAX_FRAME];
    int          rx_fill, rx_target;
    logic [19:0] rx_idle;
    t_cfg        cfg;

    t_req pending_reqs[$];
    t_res expected_items[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   in_taken = 1'b0;

    function automatic int len_for_type(input logic [7:0] t, output logic [1:0] cls);
        cls = 2'd0;
        if (t == cfg.type_par) return 12;
        if (t == cfg.type_act) begin cls = 2'd1; return 20; end
        if (t == cfg.type_mot) begin cls = 2'd2; return 28; end
        return 0;
    endfunction

    function automatic int buf16(input int p);
        return {rx_buf[p+1], rx_buf[p]};
    endfunction

    function automatic bit header_valid(input int p);
        logic [1:0] c;
        int w;
        w = len_for_type(rx_buf[p+3], c);
        return rx_buf[p+2] == cfg.version && w != 0 && buf16(p+4) == w;
    endfunction

    task automatic push_status(input logic [2:0] st);
        t_res r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        expected_items.push_back(r);
    endtask

    task automatic resync_buffer();
        int rem;
        for (int i = 1; i + 1 < rx_fill; i++) begin
            if (rx_buf[i] != SYNC_A || rx_buf[i+1] != SYNC_B) continue;
            rem = rx_fill - i;
            if (rem >= 6 && !header_valid(i)) continue;
            for (int k = 0; k < rem; k++) rx_buf[k] = rx_buf[i+k];
            rx_fill = rem;
            rx_target = (rem >= 6) ? 16 + buf16(4) : 0;
            return;
        end
        if (rx_fill != 0 && rx_buf[rx_fill-1] == SYNC_A) begin
            rx_buf[0] = SYNC_A;
            rx_fill = 1;
        end else begin
            rx_fill = 0;
        end
        rx_target = 0;
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic [1:0] cls;
        logic [15:0] crc;
        int w, len;
        t_res r;
        if (rx_fill == 0) begin
            if (b == SYNC_A) begin rx_buf[0] = b; rx_fill = 1; end
            return;
        end
        if (rx_fill == 1) begin
            if (b == SYNC_B) begin
                rx_buf[1] = b; rx_fill = 2;
            end else begin
                rx_fill = 0; rx_target = 0;
                if (b == SYNC_A) begin rx_buf[0] = b; rx_fill = 1; end
            end
            return;
        end
        if (rx_fill >= MAX_FRAME) begin
            rx_fill = 0; rx_target = 0;
            return;
        end
        rx_buf[rx_fill] = b;
        rx_fill++;
        if (rx_fill == 6) begin
            w = len_for_type(rx_buf[3], cls);
            if (rx_buf[2] != cfg.version || w == 0) begin
                resync_buffer(); push_status(ST_BAD_HDR); return;
            end
            if (buf16(4) != w) begin
                resync_buffer(); push_status(ST_BAD_LEN); return;
            end
            rx_target = 16 + w;
        end
        if (rx_target != 0 && rx_fill == rx_target) begin
            len = buf16(4);
            w = len_for_type(rx_buf[3], cls);
            crc = 16'hFFFF;
            for (int i = 2; i < 14 + len; i++) begin
                crc = crc ^ {rx_buf[i], 8'h00};
                for (int k = 0; k < 8; k++)
                    crc = crc[15] ? ({crc[14:0], 1'b0} ^ 16'h1021) : {crc[14:0], 1'b0};
            end
            if (buf16(14 + len) != crc) begin
                resync_buffer(); push_status(ST_BAD_CRC); return;
            end
            for (int i = 0; i < len; i++) begin
                r.status = ST_PAYLOAD;
                r.frame_class = cls;
                r.payload_byte = rx_buf[14+i];
                r.byte_index = i[4:0];
                r.last = (i + 1 == len);
                expected_items.push_back(r);
            end
            rx_fill = 0; rx_target = 0;
        end
    endtask

    task automatic predict_request(input t_req q);
        case (q.kind)
            KIND_BYTE: begin
                rx_idle = '0;
                predict_byte(q.rx_byte);
            end
            KIND_TICK: begin
                if (rx_fill == 0) begin
                    rx_idle = '0;
                end else begin
                    if (rx_idle != TICK_MAX) rx_idle++;
                    if (rx_idle >= cfg.timeout) begin
                        rx_fill = 0; rx_target = 0; rx_idle = '0;
                        push_status(ST_TIMEOUT);
                    end
                end
            end
            KIND_OVF: begin
                rx_fill = 0; rx_target = 0; rx_idle = '0;
                push_status(ST_OVF);
            end
            default: ;
        endcase
    endtask

    // Driver: one request at a time, with a random gap before each.
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                predict_request('{i_kind, i_rx_byte});
                void'(pending_reqs.pop_front());
                send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
                i_in_valid <= 1'b0;
            end else if (!i_in_valid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_reqs.size() != 0) begin
                    i_kind <= pending_reqs[0].kind;
                    i_rx_byte <= pending_reqs[0].rx_byte;
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: stall drawn per result, compare at the rising edge.
    int recv_gap = 0;
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n) begin
            in_taken <= i_in_valid && !o_in_stall;
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_out_valid && !i_out_stall) begin
                got = '{o_status, o_frame_class, o_payload_byte, o_byte_index, o_last};
                if (expected_items.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    want = expected_items.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
                    end
                end
                recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            end
        end
    end
    always @(negedge i_clk) begin
        if (recv_gap > 0) begin
            i_out_stall <= 1'b1;
            recv_gap--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v; penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_VERSION:  cfg.version  = v[7:0];
            REG_TYPE_PAR: cfg.type_par = v[7:0];
            REG_TYPE_ACT: cfg.type_act = v[7:0];
            REG_TYPE_MOT: cfg.type_mot = v[7:0];
            REG_TIMEOUT:  cfg.timeout  = v[19:0];
            default: ;
        endcase
    endtask

    task automatic add_byte(input logic [7:0] b);
        pending_reqs.push_back('{KIND_BYTE, b});
    endtask

    task automatic add_kind(input logic [1:0] k);
        pending_reqs.push_back('{k, 8'($urandom)});
    endtask

    // Queue one frame; damage selects a broken field (0 none).
    task automatic add_frame(input int cls, input int damage);
        logic [7:0] f [MAX_FRAME];
        logic [15:0] crc;
        int len;
        len = (cls == 0) ? 12 : (cls == 1) ? 20 : 28;
        f[0] = SYNC_A; f[1] = SYNC_B; f[2] = cfg.version;
        f[3] = (cls == 0) ? cfg.type_par : (cls == 1) ? cfg.type_act : cfg.type_mot;
        f[4] = len[7:0]; f[5] = 8'h00;
        for (int i = 6; i < 14 + len; i++) f[i] = 8'($urandom);
        crc = 16'hFFFF;
        for (int i = 2; i < 14 + len; i++) begin
            crc = crc ^ {f[i], 8'h00};
            for (int k = 0; k < 8; k++)
                crc = crc[15] ? ({crc[14:0], 1'b0} ^ 16'h1021) : {crc[14:0], 1'b0};
        end
        f[14+len] = crc[7:0]; f[15+len] = crc[15:8];
        case (damage)
            1: f[2] = f[2] ^ 8'($urandom_range(1, 255));
            2: f[5] = 8'($urandom_range(1, 255));
            3: f[14+len] = f[14+len] ^ 8'($urandom_range(1, 255));
            default: ;
        endcase
        for (int i = 0; i < 16 + len; i++) add_byte(f[i]);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || i_in_valid || expected_items.size() != 0)
            @(posedge i_clk);
        // An error result is loaded only after the resync, from the status state.
        repeat (200) @(posedge i_clk);
    endtask

    int r;
    initial begin
        cfg = '{8'd1, 8'd0, 8'd1, 8'd2, TIMEOUT_DEFAULT};
        rx_fill = 0; rx_target = 0; rx_idle = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset settings.
        add_frame(0, 0); add_frame(1, 0);
        add_frame(0, 1); add_frame(0, 2); add_frame(0, 3);
        add_kind(KIND_OVF); add_kind(2'd3);
        add_byte(8'hA5); add_byte(8'hA5); add_byte(8'h5A); add_byte(8'hFF);
        add_byte(8'h00); add_byte(8'h0C); add_byte(8'hA5); add_byte(8'h5A);
        add_kind(KIND_OVF);
        drain();

        // Extremes: short timeout, full-scale codes, overlapping types.
        reg_write(REG_VERSION, 32'hFF);
        reg_write(REG_TYPE_PAR, 32'hFF);
        reg_write(REG_TYPE_ACT, 32'hFF);
        reg_write(REG_TYPE_MOT, 32'h00);
        reg_write(REG_TIMEOUT, 32'd1);
        add_byte(8'hA5); add_kind(KIND_TICK); add_kind(KIND_TICK);
        add_frame(0, 0);
        drain();
        reg_write(REG_TIMEOUT, 32'd0);
        add_byte(8'hA5); add_kind(KIND_TICK);
        drain();
        reg_write(REG_TIMEOUT, 32'hFFFFF);
        reg_write(REG_VERSION, 32'h00);
        reg_write(REG_TYPE_PAR, 32'h3C);
        reg_write(REG_TYPE_ACT, 32'hC3);
        reg_write(REG_TYPE_MOT, 32'hA5);
        add_frame(2, 0);
        drain();
        reg_write(REG_TIMEOUT, 32'd4);

        // Random part: mostly frames with random content, plus noise and breaks.
        for (int n = 0; n < 2; n++) begin
            r = $urandom_range(0, 9);
            if (r < 5) add_frame($urandom_range(0, 2), 0);
            else if (r < 7) add_frame($urandom_range(0, 2), $urandom_range(1, 3));
            else if (r == 7) begin
                for (int k = $urandom_range(1, 6); k > 0; k--) add_byte(8'($urandom));
                add_byte(8'hA5);
            end else if (r == 8) begin
                add_byte(8'hA5); add_byte(8'h5A);
                for (int k = $urandom_range(0, 6); k > 0; k--) add_kind(KIND_TICK);
            end else add_kind(2'($urandom_range(1, 3)));
            if (n == 0) begin
                // Hold the sender until the receiver has everything.
                drain();
                reg_write(REG_TIMEOUT, 32'd50000);
            end
        end
        drain();

        if (mismatches == 0 && expected_items.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
